FILE: design/adsr_pkg.sv
package adsr_pkg;

   // Input and result payloads.
   typedef struct packed {
      logic [1:0] req_type;
      logic       hard_restart;
   } req_payload_type;

   typedef struct packed {
      logic [14:0] level;
      logic [2:0]  stage_code;
   } rsp_payload_type;

   // Request codes on req_type.
   localparam logic [1:0] REQ_TICK      = 2'd0;
   localparam logic [1:0] REQ_GATE_ON   = 2'd1;
   localparam logic [1:0] REQ_GATE_OFF  = 2'd2;
   localparam logic [1:0] REQ_RETRIGGER = 2'd3;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_GATE_ON = 2'd1,
      OP_GATE_OFF = 2'd2,
      OP_RETRIG  = 2'd3
   } op_type;

   // Decoded command handed from the front to the back.
   typedef struct packed {
      op_type op;
      logic   hard;
   } cmd_type;

   typedef enum logic [2:0] {
      STAGE_IDLE    = 3'd0,
      STAGE_ATTACK  = 3'd1,
      STAGE_DECAY   = 3'd2,
      STAGE_SUSTAIN = 3'd3,
      STAGE_RELEASE = 3'd4
   } stage_type;

   // Register file.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_STEP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_STEP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_STEP  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LEVEL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_COEF  = 3'd4;

   typedef struct packed {
      logic [31:0] attack_step;
      logic [31:0] decay_step;
      logic [31:0] release_step;
      logic [14:0] sustain_level;
      logic [24:0] release_coef;
   } cfg_type;

   localparam logic [31:0] ATTACK_STEP_RESET   = 32'd4294967295;
   localparam logic [31:0] DECAY_STEP_RESET    = 32'd1526828;
   localparam logic [31:0] RELEASE_STEP_RESET  = 32'd23863;
   localparam logic [14:0] SUSTAIN_LEVEL_RESET = 15'd16384;
   localparam logic [24:0] RELEASE_COEF_RESET  = 25'd1034;

   localparam logic [14:0] LEVEL_FULL = 15'd32767;
   localparam logic [24:0] COEF_ONE   = 25'd16777216;

   localparam int QUEUE_DEPTH = 2;

endpackage

FILE: design/adsr_front.sv
module adsr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  adsr_pkg::req_payload_type req_data,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output adsr_pkg::cmd_type        cmd
);
   import adsr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          decoded;
   logic             push, pop;

   // The hard restart flag only matters for a retrigger, so it is dropped here for every other request.
   always_comb begin
      decoded.hard = 1'b0;
      unique case (req_data.req_type)
         REQ_TICK:     decoded.op = OP_TICK;
         REQ_GATE_ON:  decoded.op = OP_GATE_ON;
         REQ_GATE_OFF: decoded.op = OP_GATE_OFF;
         default: begin
            decoded.op   = OP_RETRIG;
            decoded.hard = req_data.hard_restart;
         end
      endcase
   end

   assign req_ready = (count_ff != CNT_FULL);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("command queue count out of range");

   a_count_grows : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue lost a transfer");

endmodule

FILE: design/adsr_back.sv
module adsr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  adsr_pkg::cfg_type         cfg,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  adsr_pkg::cmd_type         cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output adsr_pkg::rsp_payload_type rsp_data
);
   import adsr_pkg::*;

   typedef enum logic [5:0] {
      SEQ_WAIT       = 6'b000001,
      SEQ_SQUARE     = 6'b000010,
      SEQ_QUART      = 6'b000100,
      SEQ_SCALE      = 6'b001000,
      SEQ_CURVE_DONE = 6'b010000,
      SEQ_REL_DONE   = 6'b100000
   } seq_type;

   seq_type            seq_ff, seq_in;
   stage_type          stage_ff, stage_in;
   logic [31:0]        phase_ff, phase_in;
   logic [31:0]        inc_ff, inc_in;
   logic [14:0]        start_ff, start_in;
   logic [14:0]        target_ff, target_in;
   logic [14:0]        cur_ff, cur_in;
   logic [30:0]        rel_ff, rel_in;
   logic               gate_ff, gate_in;
   logic               hard_ff, hard_in;
   logic               wrap_ff, wrap_in;
   logic               moved_ff, moved_in;
   logic [31:0]        sq_ff, sq_in;
   logic signed [32:0] blend_ff, blend_in;
   logic [55:0]        rel_prod_ff, rel_prod_in;
   logic               out_valid_ff, out_valid_in;
   rsp_payload_type    out_ff, out_in;

   logic [32:0]        phase_sum;
   logic [24:0]        coef_eff;
   logic [15:0]        sq_sel;
   logic [15:0]        curve;
   logic signed [15:0] diff;
   logic signed [16:0] curve_s;
   logic [30:0]        rel_next;
   logic               attack_hard;
   logic               finish;

   assign phase_sum = {1'b0, phase_ff} + {1'b0, inc_ff};
   assign coef_eff  = (cfg.release_coef == '0 || cfg.release_coef > COEF_ONE) ?
                      COEF_ONE : cfg.release_coef;
   assign rel_next  = rel_ff - rel_prod_ff[54:24];
   assign diff      = $signed({1'b0, target_ff}) - $signed({1'b0, start_ff});
   assign curve_s   = $signed({1'b0, curve});
   assign cmd_ready = (seq_ff == SEQ_WAIT) && (!out_valid_ff || rsp_ready);
   assign attack_hard = (cmd.op == OP_RETRIG) ? cmd.hard : hard_ff;

   always_comb begin
      seq_in       = seq_ff;
      stage_in     = stage_ff;
      phase_in     = phase_ff;
      inc_in       = inc_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      cur_in       = cur_ff;
      rel_in       = rel_ff;
      gate_in      = gate_ff;
      hard_in      = hard_ff;
      wrap_in      = wrap_ff;
      moved_in     = moved_ff;
      sq_in        = sq_ff;
      blend_in     = blend_ff;
      rel_prod_in  = rel_prod_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      finish       = 1'b0;
      sq_sel       = (stage_ff == STAGE_ATTACK) ? phase_ff[31:16] : ~phase_ff[31:16];
      curve        = (stage_ff == STAGE_ATTACK) ? sq_ff[31:16] : ~sq_ff[31:16];

      unique case (seq_ff)
         SEQ_WAIT: begin
            if (cmd_valid && cmd_ready) begin
               unique case (cmd.op)
                  OP_TICK: begin
                     unique case (stage_ff)
                        STAGE_SUSTAIN: begin
                           cur_in = cfg.sustain_level;
                           finish = 1'b1;
                        end
                        STAGE_RELEASE: begin
                           phase_in    = phase_sum[31:0];
                           wrap_in     = phase_sum[32];
                           moved_in    = (inc_ff != '0);
                           rel_prod_in = {25'b0, rel_ff} * {31'b0, coef_eff};
                           seq_in      = SEQ_REL_DONE;
                        end
                        STAGE_ATTACK, STAGE_DECAY: begin
                           phase_in = phase_sum[31:0];
                           if (!phase_sum[32]) begin
                              seq_in = SEQ_SQUARE;
                           end else if (stage_ff == STAGE_ATTACK) begin
                              start_in  = LEVEL_FULL;
                              target_in = cfg.sustain_level;
                              phase_in  = '0;
                              inc_in    = cfg.decay_step;
                              stage_in  = STAGE_DECAY;
                              cur_in    = LEVEL_FULL;
                              finish    = 1'b1;
                           end else if (gate_ff) begin
                              stage_in = STAGE_SUSTAIN;
                              cur_in   = cfg.sustain_level;
                              finish   = 1'b1;
                           end else begin
                              phase_in = '0;
                              inc_in   = cfg.release_step;
                              stage_in = STAGE_RELEASE;
                              cur_in   = cfg.sustain_level;
                              rel_in   = {cfg.sustain_level, 16'b0};
                              finish   = 1'b1;
                           end
                        end
                        default: begin
                           cur_in = '0;
                           finish = 1'b1;
                        end
                     endcase
                  end
                  OP_GATE_OFF: begin
                     gate_in = 1'b0;
                     if (stage_ff == STAGE_ATTACK || stage_ff == STAGE_DECAY ||
                         stage_ff == STAGE_SUSTAIN) begin
                        phase_in = '0;
                        inc_in   = cfg.release_step;
                        rel_in   = {cur_ff, 16'b0};
                        stage_in = STAGE_RELEASE;
                     end
                     finish = 1'b1;
                  end
                  default: begin
                     // Gate on and retrigger both restart the attack segment.
                     if (cmd.op == OP_RETRIG) begin
                        hard_in = cmd.hard;
                     end
                     gate_in   = 1'b1;
                     start_in  = (attack_hard || stage_ff == STAGE_IDLE) ? '0 : cur_ff;
                     target_in = LEVEL_FULL;
                     phase_in  = '0;
                     inc_in    = cfg.attack_step;
                     stage_in  = STAGE_ATTACK;
                     finish    = 1'b1;
                  end
               endcase
            end
         end
         SEQ_SQUARE: begin
            sq_in  = {16'b0, sq_sel} * {16'b0, sq_sel};
            seq_in = SEQ_QUART;
         end
         SEQ_QUART: begin
            sq_in  = {16'b0, sq_ff[31:16]} * {16'b0, sq_ff[31:16]};
            seq_in = SEQ_SCALE;
         end
         SEQ_SCALE: begin
            blend_in = diff * curve_s;
            seq_in   = SEQ_CURVE_DONE;
         end
         SEQ_CURVE_DONE: begin
            // An arithmetic shift of the product gives the floored quotient.
            cur_in = start_ff + blend_ff[30:16];
            finish = 1'b1;
            seq_in = SEQ_WAIT;
         end
         SEQ_REL_DONE: begin
            if (wrap_ff || rel_next == '0 || (moved_ff && rel_next[30:16] == '0)) begin
               stage_in = STAGE_IDLE;
               cur_in   = '0;
               rel_in   = '0;
               phase_in = '0;
               inc_in   = '0;
            end else begin
               rel_in = rel_next;
               cur_in = rel_next[30:16];
            end
            finish = 1'b1;
            seq_in = SEQ_WAIT;
         end
         default: seq_in = SEQ_WAIT;
      endcase

      if (finish) begin
         out_valid_in      = 1'b1;
         out_in.level      = cur_in;
         out_in.stage_code = stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_WAIT;
         stage_ff     <= STAGE_IDLE;
         phase_ff     <= '0;
         inc_ff       <= '0;
         start_ff     <= '0;
         target_ff    <= '0;
         cur_ff       <= '0;
         rel_ff       <= '0;
         gate_ff      <= 1'b0;
         hard_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         stage_ff     <= stage_in;
         phase_ff     <= phase_in;
         inc_ff       <= inc_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         cur_ff       <= cur_in;
         rel_ff       <= rel_in;
         gate_ff      <= gate_in;
         hard_ff      <= hard_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wrap_ff     <= wrap_in;
      moved_ff    <= moved_in;
      sq_ff       <= sq_in;
      blend_ff    <= blend_in;
      rel_prod_ff <= rel_prod_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_busy_slot_free : assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_WAIT) |-> !out_valid_ff)
      else $error("result register occupied while a tick is in progress");

   a_idle_is_silent : assert property (@(posedge clock) disable iff (reset)
      (stage_ff == STAGE_IDLE) |-> (cur_ff == '0))
      else $error("nonzero level in the idle stage");

   a_attack_target : assert property (@(posedge clock) disable iff (reset)
      (stage_ff == STAGE_ATTACK) |-> (target_ff == LEVEL_FULL))
      else $error("attack segment does not aim at full scale");

endmodule

FILE: design/adsr_envelope_generator.sv
// ADSR envelope generator driven by events.
// Each transfer on the req_ channel is one event (sample tick, gate on, gate off
// or retrigger); each produces exactly one result on the rsp_ channel carrying
// the Q15 level and the stage after that event, in order.
// The csr_ channel writes the five registers by index; csr_ready is always high.
// Registers should only be written while no event is outstanding.
// An accepted event enters a two-entry command queue, so req_ready stays high
// while a result waits in the output register. The execution unit takes one
// event at a time. Gate events, idle and sustain ticks and ticks that end a
// segment are finished in its wait state, which registers the result. A
// release tick passes the release-done state for one 31x25 multiply. An attack
// or decay tick passes the square, quart, scale and curve-done states through
// three chained 16-bit multiplies (square, square, scale) before its result is registered.
// When rsp_ready is low the result is held; the queue absorbs two more events
// and then req_ready drops. Reset clears the envelope to idle at level zero and
// loads the register defaults.
module adsr_envelope_generator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  adsr_pkg::req_payload_type               req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output adsr_pkg::rsp_payload_type               rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [adsr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [31:0]                             csr_data
);
   import adsr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ATTACK_STEP:   cfg_in.attack_step   = csr_data;
            CSR_DECAY_STEP:    cfg_in.decay_step    = csr_data;
            CSR_RELEASE_STEP:  cfg_in.release_step  = csr_data;
            CSR_SUSTAIN_LEVEL: cfg_in.sustain_level = csr_data[14:0];
            CSR_RELEASE_COEF:  cfg_in.release_coef  = csr_data[24:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_step   <= ATTACK_STEP_RESET;
         cfg_ff.decay_step    <= DECAY_STEP_RESET;
         cfg_ff.release_step  <= RELEASE_STEP_RESET;
         cfg_ff.sustain_level <= SUSTAIN_LEVEL_RESET;
         cfg_ff.release_coef  <= RELEASE_COEF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   adsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
